// ===== src/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // field widths
  localparam int CH_W        = 8;
  localparam int HUE_W       = 11;
  localparam int SAT_W       = 9;
  localparam int VAL_W       = 8;
  // hue numerator before scaling, below 6 * 255
  localparam int NUM_W       = 11;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - HUE_W - SAT_W - VAL_W;

  localparam int DEF_FRACTION_BITS = 8;

  // which channel holds the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

endpackage

// ===== src/rgb_to_hsv_fixed.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Ports                          | Payload
// --------+-----+--------------------------------+-------------------------------------
// in      | in  | in_tvalid in_tready in_tdata   | red[7:0] green[15:8] blue[23:16]
// out     | out | out_tvalid out_tready out_tdata| hue[10:0] sat[19:11] value[27:20]
//
// One pixel per clock, sustained while out_tready is not held low. The pipeline is
// one input register, one min/max stage, one hue numerator stage, then one
// restoring-division step per stage for the hue quotient (FRACTION_BITS + 3
// bits); the saturation quotient runs in the same stages alongside.
// Reset (rst_n low, synchronous) clears only the valid bits; data registers
// are not reset. A stall on out_tready freezes the whole pipeline and drops
// in_tready in the same cycle, so no request is lost or repeated.

module rgb_to_hsv_fixed #(
  parameter int FRACTION_BITS = rgbhsv_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // red[7:0], green[15:8], blue[23:16]
  input  logic [rgbhsv_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hue[10:0], saturation[19:11], value[27:20], zeros above
  output logic [rgbhsv_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import rgbhsv_pkg::*;

  // quotient widths: hue < 6 * 2^F, saturation <= 2^F
  localparam int QH = FRACTION_BITS + 3;
  localparam int QS = FRACTION_BITS + 1;
  localparam int NS = QH;

  localparam logic [QS-1:0] SAT_ONE = QS'(1) << FRACTION_BITS;
  localparam logic [QH-1:0] HUE_LIM = QH'(6) << FRACTION_BITS;

  // whole pipe moves together; stops only when the output is full and held
  logic advance;

  // ---------------- stage A: input register ----------------
  logic            a_v_r;
  logic [CH_W-1:0] a_red_r, a_green_r, a_blue_r;

  // ---------------- stage B: max / min / sector ----------------
  logic            b_v_r;
  logic [CH_W-1:0] b_red_r, b_green_r, b_blue_r;
  logic [CH_W-1:0] b_max_r, b_min_r;
  logic [1:0]      b_sel_r;
  logic [CH_W-1:0] b_max_nxt, b_min_nxt;
  logic [1:0]      b_sel_nxt;

  // ---------------- divider stages 0..NS ----------------
  logic             v_r    [0:NS];
  logic [NUM_W-1:0] num_r  [0:NS];
  logic [CH_W-1:0]  hdiv_r [0:NS];
  logic [CH_W-1:0]  hrem_r [0:NS];
  logic [QH-1:0]    hq_r   [0:NS];
  logic [CH_W-1:0]  sd_r   [0:NS];
  logic [CH_W-1:0]  sdiv_r [0:NS];
  logic [CH_W-1:0]  srem_r [0:NS];
  logic [QS-1:0]    sq_r   [0:NS];
  logic [VAL_W-1:0] val_r  [0:NS];

  // stage-0 front end
  logic [CH_W-1:0]  d_nxt;
  logic [8:0]       diff_nxt;
  logic [11:0]      base_nxt, num12_nxt, d12_nxt;
  logic [NUM_W-1:0] num_nxt;
  logic [CH_W-1:0]  hdiv_nxt, sdiv_nxt;

  assign advance   = !v_r[NS] || out_tready;
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (advance) begin
      a_v_r <= in_tvalid;
    end
    if (advance) begin
      a_red_r   <= in_tdata[CH_W-1:0];
      a_green_r <= in_tdata[2*CH_W-1:CH_W];
      a_blue_r  <= in_tdata[3*CH_W-1:2*CH_W];
    end
  end

  // max with red first, then green, as the sector priority requires
  always_comb begin
    b_max_nxt = a_red_r;
    b_min_nxt = a_red_r;
    if (a_green_r > b_max_nxt) b_max_nxt = a_green_r;
    if (a_blue_r  > b_max_nxt) b_max_nxt = a_blue_r;
    if (a_green_r < b_min_nxt) b_min_nxt = a_green_r;
    if (a_blue_r  < b_min_nxt) b_min_nxt = a_blue_r;
    if (b_max_nxt == a_red_r) begin
      b_sel_nxt = SEL_RED;
    end else if (b_max_nxt == a_green_r) begin
      b_sel_nxt = SEL_GREEN;
    end else begin
      b_sel_nxt = SEL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (advance) begin
      b_v_r <= a_v_r;
    end
    if (advance) begin
      b_red_r   <= a_red_r;
      b_green_r <= a_green_r;
      b_blue_r  <= a_blue_r;
      b_max_r   <= b_max_nxt;
      b_min_r   <= b_min_nxt;
      b_sel_r   <= b_sel_nxt;
    end
  end

  // hue numerator: sector offset * d plus a signed channel difference
  always_comb begin
    d_nxt   = b_max_r - b_min_r;
    d12_nxt = {4'b0, d_nxt};
    case (b_sel_r)
      SEL_RED: begin
        diff_nxt = {1'b0, b_green_r} - {1'b0, b_blue_r};
        base_nxt = diff_nxt[8] ? ((d12_nxt << 2) + (d12_nxt << 1)) : 12'd0;
      end
      SEL_GREEN: begin
        diff_nxt = {1'b0, b_blue_r} - {1'b0, b_red_r};
        base_nxt = d12_nxt << 1;
      end
      default: begin
        diff_nxt = {1'b0, b_red_r} - {1'b0, b_green_r};
        base_nxt = d12_nxt << 2;
      end
    endcase
    num12_nxt = base_nxt + {{3{diff_nxt[8]}}, diff_nxt};
    // gray or black: divide zero by one so the quotients come out zero
    if (d_nxt == '0) begin
      num_nxt  = '0;
      hdiv_nxt = CH_W'(1);
    end else begin
      num_nxt  = num12_nxt[NUM_W-1:0];
      hdiv_nxt = d_nxt;
    end
    sdiv_nxt = (b_max_r == '0) ? CH_W'(1) : b_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (advance) begin
      v_r[0] <= b_v_r;
    end
    if (advance) begin
      num_r[0]  <= num_nxt;
      hdiv_r[0] <= hdiv_nxt;
      // num < 8 * d, so all but the low three bits start below the divisor
      hrem_r[0] <= CH_W'(num_nxt >> 3);
      hq_r[0]   <= '0;
      sd_r[0]   <= d_nxt;
      sdiv_r[0] <= sdiv_nxt;
      // d <= max, so d / 2 starts below the divisor
      srem_r[0] <= d_nxt >> 1;
      sq_r[0]   <= '0;
      val_r[0]  <= b_max_r;
    end
  end

  // one restoring step per stage, MSB of the quotient first
  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int JH = QH - 1 - k;
    localparam int JS = QS - 1 - k;

    logic            hbit, sbit;
    logic [CH_W:0]   htrial, strial;
    logic            hge, sge;
    logic [CH_W-1:0] hrem_nxt, srem_nxt;
    logic [QH-1:0]   hq_nxt;
    logic [QS-1:0]   sq_nxt;

    if (JH >= FRACTION_BITS) begin : g_hb
      assign hbit = num_r[k][JH-FRACTION_BITS];
    end else begin : g_hz
      assign hbit = 1'b0;
    end

    if (JS >= FRACTION_BITS) begin : g_sb
      assign sbit = sd_r[k][JS-FRACTION_BITS];
    end else begin : g_sz
      assign sbit = 1'b0;
    end

    always_comb begin
      htrial   = {hrem_r[k], hbit};
      hge      = htrial >= {1'b0, hdiv_r[k]};
      hrem_nxt = hge ? CH_W'(htrial - {1'b0, hdiv_r[k]}) : CH_W'(htrial);
      hq_nxt   = {hq_r[k][QH-2:0], hge};
      strial   = {srem_r[k], sbit};
      sge      = strial >= {1'b0, sdiv_r[k]};
      if (k < QS) begin
        srem_nxt = sge ? CH_W'(strial - {1'b0, sdiv_r[k]}) : CH_W'(strial);
        sq_nxt   = {sq_r[k][QS-2:0], sge};
      end else begin
        srem_nxt = srem_r[k];
        sq_nxt   = sq_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (advance) begin
        v_r[k+1] <= v_r[k];
      end
      if (advance) begin
        num_r[k+1]  <= num_r[k];
        hdiv_r[k+1] <= hdiv_r[k];
        hrem_r[k+1] <= hrem_nxt;
        hq_r[k+1]   <= hq_nxt;
        sd_r[k+1]   <= sd_r[k];
        sdiv_r[k+1] <= sdiv_r[k];
        srem_r[k+1] <= srem_nxt;
        sq_r[k+1]   <= sq_nxt;
        val_r[k+1]  <= val_r[k];
      end
    end
  end

  // last divider stage is the output register
  assign out_tvalid = v_r[NS];
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, val_r[NS], SAT_W'(sq_r[NS]), HUE_W'(hq_r[NS])};

  // ---------------- assertions ----------------
  a_sat_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sq_r[NS] <= SAT_ONE)
    else $error("saturation quotient above one");

  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hq_r[NS] < HUE_LIM)
    else $error("hue quotient at or above six sectors");

  a_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && val_r[NS] == '0) |-> (hq_r[NS] == '0 && sq_r[NS] == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_gray : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sd_r[NS] == '0) |-> (hq_r[NS] == '0 && sq_r[NS] == '0))
    else $error("gray pixel with nonzero hue or saturation");

  a_rem : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] |-> (hrem_r[NS] < hdiv_r[NS] && srem_r[NS] < sdiv_r[NS]))
    else $error("divider remainder not below divisor");

endmodule

// ===== tb/sv/tb_rgb_to_hsv_fixed.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hsv_fixed;
  import rgbhsv_pkg::*;

  localparam int FRAC      = DEF_FRACTION_BITS;
  localparam int HOLD_LEN  = 300;    // long output stall, fills the pipe
  localparam int TAIL_CYC  = 40;     // longer than the pipeline latency
  localparam int CYC_LIMIT = 60000;
  localparam int MAX_PRINT = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] val;
  } hsv_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [IN_TDATA_W-1:0] pixel_q[$];     // pixels waiting to be offered
  hsv_t                  hsv_expect_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;

  int unsigned cycle_cnt     = 0;
  int unsigned n_errors      = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_checked     = 0;
  int unsigned n_in_stalls   = 0;
  hsv_t        want_px;

  rgb_to_hsv_fixed #(.FRACTION_BITS(FRAC)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Golden HSV: value = max, sat = d/max, hue by sector with red tested
  // first, then green. Gray and black give hue 0.
  function automatic hsv_t predict_hsv(input logic [IN_TDATA_W-1:0] px);
    int unsigned r, g, b, mx, mn, d, num;
    hsv_t res;
    r = {24'd0, px[7:0]};
    g = {24'd0, px[15:8]};
    b = {24'd0, px[23:16]};
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res = '0;
    res.val = mx[VAL_W-1:0];
    if (mx != 0) res.sat = SAT_W'((d << FRAC) / mx);
    if (d != 0) begin
      if (mx == r) begin
        num = (g >= b) ? (g - b) : (6 * d - (b - g));
      end else if (mx == g) begin
        num = 2 * d + b - r;
      end else begin
        num = 4 * d + r - g;
      end
      res.hue = HUE_W'((num << FRAC) / d);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= MAX_PRINT)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Mostly uniform pixels, with grays, tied maxima and tiny values mixed in.
  task automatic push_random(input int n);
    logic [7:0] r, g, b, t;
    int mode;
    repeat (n) begin
      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      mode = int'($urandom_range(9));
      case (mode)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          t = (r > g) ? r : g;
          case ($urandom_range(2))
            0: begin r = t; g = t; end
            1: begin g = t; b = t; end
            default: begin r = t; b = t; end
          endcase
        end
        2: begin
          r = 8'($urandom_range(3));
          g = 8'($urandom_range(3));
          b = 8'($urandom_range(3));
        end
        default: ;
      endcase
      pixel_q.push_back({b, g, r});
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_tvalid || hsv_expect_q.size() != 0)
      @(negedge clk);
  endtask

  // Driver: records each accepted request, then offers the next pixel
  // unless it decides to idle this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && !in_tready) n_in_stalls++;
      if (in_tvalid && in_tready) begin
        hsv_expect_q.push_back(predict_hsv(in_tdata));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus one long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hsv_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 0);
      end else begin
        want_px = hsv_expect_q.pop_front();
        n_checked++;
        if (out_tdata[HUE_W-1:0] !== want_px.hue)
          report_mismatch("hue", 32'(out_tdata[HUE_W-1:0]), 32'(want_px.hue));
        if (out_tdata[HUE_W+SAT_W-1:HUE_W] !== want_px.sat)
          report_mismatch("saturation", 32'(out_tdata[HUE_W+SAT_W-1:HUE_W]),
                          32'(want_px.sat));
        if (out_tdata[HUE_W+SAT_W+VAL_W-1:HUE_W+SAT_W] !== want_px.val)
          report_mismatch("value", 32'(out_tdata[HUE_W+SAT_W+VAL_W-1:HUE_W+SAT_W]),
                          32'(want_px.val));
        if (out_tdata[OUT_TDATA_W-1:OUT_TDATA_W-OUT_PAD_W] !== '0)
          report_mismatch("padding",
                          32'(out_tdata[OUT_TDATA_W-1:OUT_TDATA_W-OUT_PAD_W]), 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, hsv_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender mostly busy, receiver stalls about half the time
    send_idle_pct = 9;
    recv_idle_pct = 51;
    // directed: black, grays, primaries, ties, each hue sector branch,
    // wrap near six sectors, full saturation, alternating bit patterns
    pixel_q.push_back({8'd0,   8'd0,   8'd0});
    pixel_q.push_back({8'd255, 8'd255, 8'd255});
    pixel_q.push_back({8'd128, 8'd128, 8'd128});
    pixel_q.push_back({8'd1,   8'd1,   8'd1});
    pixel_q.push_back({8'd0,   8'd0,   8'd255});
    pixel_q.push_back({8'd0,   8'd255, 8'd0});
    pixel_q.push_back({8'd255, 8'd0,   8'd0});
    pixel_q.push_back({8'd1,   8'd0,   8'd255});
    pixel_q.push_back({8'd254, 8'd0,   8'd255});
    pixel_q.push_back({8'd0,   8'd254, 8'd255});
    pixel_q.push_back({8'd10,  8'd200, 8'd200});
    pixel_q.push_back({8'd200, 8'd200, 8'd10});
    pixel_q.push_back({8'd200, 8'd10,  8'd200});
    pixel_q.push_back({8'd50,  8'd200, 8'd100});
    pixel_q.push_back({8'd100, 8'd200, 8'd50});
    pixel_q.push_back({8'd200, 8'd50,  8'd100});
    pixel_q.push_back({8'd200, 8'd100, 8'd50});
    pixel_q.push_back({8'd0,   8'd0,   8'd1});
    pixel_q.push_back({8'd1,   8'd1,   8'd0});
    pixel_q.push_back({8'd0,   8'd85,  8'd170});
    pixel_q.push_back({8'd255, 8'd170, 8'd85});
    pixel_q.push_back({8'd85,  8'd170, 8'd255});
    push_random(160);
    wait_drained();

    // phase 2: sender idles about half the time, receiver rarely
    send_idle_pct = 51;
    recv_idle_pct = 9;
    push_random(160);
    wait_drained();

    // phase 3: no idling; long output hold while pixels keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    push_random(60);
    wait_drained();
    push_random(120);
    wait_drained();

    repeat (TAIL_CYC) @(negedge clk);
    while (hsv_expect_q.size() != 0) begin
      want_px = hsv_expect_q.pop_front();
      report_mismatch("result never arrived, value", 0, 32'(want_px.val));
    end

    $display("covered %0d pixels (black, grays, tied maxima, all hue sectors), %0d checked",
             n_accepted, n_checked);
    $display("input stalled %0d cycles, incl. a %0d-cycle output hold", n_in_stalls,
             HOLD_LEN);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
